// ===== rtl/sine_tone_stereo_fade_unit_macros.svh =====
// Assertion macros for the stereo fade tone generator.
// Used by the port checker; no other dependencies.
`ifndef SINE_TONE_STEREO_FADE_UNIT_MACROS_SVH
`define SINE_TONE_STEREO_FADE_UNIT_MACROS_SVH

// same-cycle implication
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define STS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/sts_pkg.sv =====
// Shared types, constants and the sine table generator for the tone generator.
// No dependencies.
`default_nettype none
package sts_pkg;

	localparam int unsigned PHASE_W = 32;
	localparam int unsigned SCOUNT_W = 24;
	localparam int unsigned FSTEP_W = 31;
	localparam int unsigned LEVEL_W = 15;
	localparam int unsigned FADE_W = 32;
	localparam int unsigned GAIN_W = LEVEL_W + 16;
	localparam int unsigned MAG_W = 15;
	localparam int unsigned PROD_W = GAIN_W + MAG_W;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;
	localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd25480158;
	localparam logic [SCOUNT_W-1:0] SCOUNT_RST = 24'd441000;
	localparam logic [FSTEP_W-1:0] FSTEP_RST = 31'd4868;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = 15'd32760;

	typedef enum logic [1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_SAMPLE_COUNT = 2'd1,
		REG_FADE_STEP = 2'd2,
		REG_MAX_LEVEL = 2'd3
	} sts_reg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [SCOUNT_W-1:0] sample_count;
		logic [FSTEP_W-1:0] fade_step;
		logic [LEVEL_W-1:0] max_level;
	} sts_cfg_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic neg;
		logic [GAIN_W-1:0] gain_l;
		logic [GAIN_W-1:0] gain_r;
		logic [MAG_W-1:0] mag;
	} sts_s1_t;

	// quarter-wave entry: Taylor series in Q28, rounded half up, limited to full scale
	function automatic logic [MAG_W-1:0] sine_entry(int unsigned i, int unsigned qbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] t;
		logic [63:0] v;
		int k;
		x = (HALF_PI_Q28 * 64'(i)) >> qbits;
		x2 = (x * x) >> 28;
		term = x;
		sum = x;
		for (k = 1; k <= 5; k++) begin
			t = (term * x2) >> 28;
			case (k)
				1: term = t / 64'd6;
				2: term = t / 64'd20;
				3: term = t / 64'd42;
				4: term = t / 64'd72;
				default: term = t / 64'd110;
			endcase
			if (k == 1 || k == 3 || k == 5)
				sum = sum - term;
			else
				sum = sum + term;
		end
		v = (sum * 64'd32767 + (64'd1 << 27)) >> 28;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[MAG_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sts_if.sv =====
// Request and sample channel interfaces (valid/ready) for the tone generator.
// No dependencies.
`default_nettype none
interface sts_tick_if;
	logic valid;
	logic ready;
	logic tick;
	modport source(output valid, output tick, input ready);
	modport sink(input valid, input tick, output ready);
endinterface

interface sts_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic last_of_run;
	modport source(output valid, output left_sample, output right_sample,
		output last_of_run, input ready);
	modport sink(input valid, input left_sample, input right_sample,
		input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/sts_front.sv =====
// Front stage: phase, fade and run counters, sine ROM read, gain split.
// Depends on sts_pkg and sts_tick_if.
`default_nettype none
module sts_front
	import sts_pkg::*;
#(
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input sts_cfg_t cfg,
	sts_tick_if.sink tick_ch,
	input logic s2_ready,
	output sts_s1_t s1
);

	localparam int unsigned QB = SINE_TABLE_BITS - 2;
	localparam int unsigned QLEN = 1 << QB;
	localparam int unsigned CMP_W = ((COUNT_BITS > SCOUNT_W) ? COUNT_BITS : SCOUNT_W) + 1;

	logic [MAG_W-1:0] rom_tbl [QLEN];

	for (genvar gi = 0; gi < QLEN; gi++) begin : g_rom
		localparam logic [MAG_W-1:0] ENT = sine_entry(gi, QB);
		assign rom_tbl[gi] = ENT;
	end

	logic [PHASE_W-1:0] phase_q;
	logic [COUNT_BITS-1:0] index_q;
	logic [FADE_W-1:0] fade_q;

	logic v_s1;
	logic last_s1;
	logic neg_s1;
	logic full_s1;
	logic [GAIN_W-1:0] gl_s1;
	logic [GAIN_W-1:0] gr_s1;
	logic [MAG_W-1:0] rom_s1;

	logic [SINE_TABLE_BITS-1:0] addr;
	logic [1:0] quad;
	logic [QB-1:0] j;
	logic [QB-1:0] j_neg;
	logic [QB-1:0] rom_idx;
	logic [GAIN_W-1:0] top_gain;
	logic [GAIN_W-1:0] gain_l;
	logic [GAIN_W-1:0] gain_r;
	logic [CMP_W-1:0] cnt_next;
	logic last;
	logic [FADE_W:0] fade_sum;
	logic [FADE_W-1:0] fade_next;
	logic in_ready;
	logic fire;

	assign addr = phase_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign quad = addr[SINE_TABLE_BITS-1 -: 2];
	assign j = addr[QB-1:0];
	assign j_neg = '0 - j;
	assign rom_idx = quad[0] ? j_neg : j;

	assign top_gain = {cfg.max_level, 16'd0};
	assign gain_l = (fade_q > {1'b0, top_gain}) ? top_gain : fade_q[GAIN_W-1:0];
	assign gain_r = top_gain - gain_l;

	assign cnt_next = CMP_W'(index_q) + CMP_W'(1);
	assign last = cnt_next >= CMP_W'(cfg.sample_count);

	assign fade_sum = {1'b0, fade_q} + (FADE_W+1)'(cfg.fade_step);
	assign fade_next = fade_sum[FADE_W] ? '1 : fade_sum[FADE_W-1:0];

	assign in_ready = !v_s1 || s2_ready;
	assign tick_ch.ready = in_ready;
	assign fire = tick_ch.valid && in_ready && tick_ch.tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
			fade_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= fire;
			if (fire) begin
				if (last) begin
					phase_q <= '0;
					index_q <= '0;
					fade_q <= '0;
				end else begin
					phase_q <= phase_q + cfg.phase_step;
					index_q <= cnt_next[COUNT_BITS-1:0];
					fade_q <= fade_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rom_s1 <= rom_tbl[rom_idx];
			gl_s1 <= gain_l;
			gr_s1 <= gain_r;
			neg_s1 <= quad[1];
			full_s1 <= quad[0] && (j == '0);
			last_s1 <= last;
		end
	end

	assign s1.valid = v_s1;
	assign s1.last = last_s1;
	assign s1.neg = neg_s1;
	assign s1.gain_l = gl_s1;
	assign s1.gain_r = gr_s1;
	assign s1.mag = full_s1 ? FULL_SCALE : rom_s1;

endmodule
`default_nettype wire

// ===== rtl/sts_mix.sv =====
// Gain multiply, scale by full scale, sign and output register.
// Depends on sts_pkg and sts_sample_if.
`default_nettype none
module sts_mix
	import sts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input sts_s1_t s1,
	output logic s2_ready,
	sts_sample_if.source sample_ch
);

	localparam logic [15:0] D1 = 16'd32767;
	localparam logic [15:0] D2 = 16'd65534;

	// trunc(p / (32767 * 2^16)), then sign
	function automatic logic [SAMPLE_W-1:0] scale(logic [PROD_W-1:0] p, logic neg);
		logic [29:0] x;
		logic [14:0] q_est;
		logic [15:0] r;
		logic [15:0] q;
		x = p[PROD_W-1:16];
		q_est = x[29:15];
		r = 16'(x[14:0]) + 16'(q_est);
		q = 16'(q_est) + ((r >= D2) ? 16'd2 : ((r >= D1) ? 16'd1 : 16'd0));
		return neg ? ('0 - q) : q;
	endfunction

	logic v_s2;
	logic neg_s2;
	logic last_s2;
	logic [PROD_W-1:0] pl_s2;
	logic [PROD_W-1:0] pr_s2;

	logic out_v_q;
	logic last_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [SAMPLE_W-1:0] right_q;
	logic adv_out;

	assign adv_out = !out_v_q || sample_ch.ready;
	assign s2_ready = !v_s2 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_ready)
				v_s2 <= s1.valid;
			if (adv_out)
				out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1.valid) begin
			pl_s2 <= PROD_W'(s1.gain_l) * PROD_W'(s1.mag);
			pr_s2 <= PROD_W'(s1.gain_r) * PROD_W'(s1.mag);
			neg_s2 <= s1.neg;
			last_s2 <= s1.last;
		end
		if (adv_out && v_s2) begin
			left_q <= scale(pl_s2, neg_s2);
			right_q <= scale(pr_s2, neg_s2);
			last_q <= last_s2;
		end
	end

	assign sample_ch.valid = out_v_q;
	assign sample_ch.left_sample = left_q;
	assign sample_ch.right_sample = right_q;
	assign sample_ch.last_of_run = last_q;

endmodule
`default_nettype wire

// ===== rtl/sine_tone_stereo_fade_unit.sv =====
// Top level of the stereo fade tone generator: configuration registers and stages.
// Depends on sts_pkg, sts_if, sts_front and sts_mix.
//
// channel    dir  payload                                  handshake
// tick_ch    in   tick                                     valid/ready
// sample_ch  out  left_sample, right_sample, last_of_run   valid/ready
// cfg_*      in   cfg_idx, cfg_wdata                       cfg_we
//
// One request per cycle while the output is not stalled; a sample passes the front, multiply and output registers.
// Rate is set by the phase/fade accumulator update, one per cycle.
// A request with tick low is taken but yields no sample.
// Output stalls back up stage by stage; bubbles are squeezed out.
// Reset clears accumulators and valids; the sine ROM is constant.
`default_nettype none
module sine_tone_stereo_fade_unit
	import sts_pkg::*;
#(
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	sts_tick_if.sink tick_ch,
	sts_sample_if.source sample_ch
);

	sts_cfg_t cfg_q;
	sts_s1_t s1;
	logic s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= PHASE_STEP_RST;
			cfg_q.sample_count <= SCOUNT_RST;
			cfg_q.fade_step <= FSTEP_RST;
			cfg_q.max_level <= LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_wdata[PHASE_W-1:0];
				REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_wdata[SCOUNT_W-1:0];
				REG_FADE_STEP: cfg_q.fade_step <= cfg_wdata[FSTEP_W-1:0];
				REG_MAX_LEVEL: cfg_q.max_level <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	sts_front #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.tick_ch(tick_ch),
		.s2_ready(s2_ready),
		.s1(s1)
	);

	sts_mix u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.s1(s1),
		.s2_ready(s2_ready),
		.sample_ch(sample_ch)
	);

endmodule
`default_nettype wire

// ===== rtl/sts_checker.sv =====
// Port-level checks for the stereo fade tone generator, bound to the top level.
// Depends on sine_tone_stereo_fade_unit_macros.svh.
`default_nettype none
`include "sine_tone_stereo_fade_unit_macros.svh"
module sts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] left,
	input logic signed [15:0] right,
	input logic last
);

	`STS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(left) && $stable(right) && $stable(last), "stalled sample changed")

	`STS_ASSERT_IMP(a_sign_match, clk, arst_n, out_valid, !(left < 0 && right > 0) && !(left > 0 && right < 0) && left != -16'sd32768 && right != -16'sd32768, "channel sign or range mismatch")

	`STS_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "request blocked with empty output")

endmodule

bind sine_tone_stereo_fade_unit sts_checker u_sts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(tick_ch.ready),
	.out_valid(sample_ch.valid),
	.out_ready(sample_ch.ready),
	.left(sample_ch.left_sample),
	.right(sample_ch.right_sample),
	.last(sample_ch.last_of_run)
);
`default_nettype wire
